FILE: design/dhs_pkg.sv
// Package: payload types, codes and the task-to-identifier function.
`timescale 1ns / 1ps
package dhs_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int MS_WIDTH       = 16;

   localparam logic [1:0] REG_SELECT_DWELL = 2'd0;
   localparam logic [1:0] REG_COMM_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_MOVE_TIMEOUT = 2'd2;

   localparam logic [MS_WIDTH-1:0] SELECT_DWELL_RESET = 16'd100;
   localparam logic [MS_WIDTH-1:0] COMM_TIMEOUT_RESET = 16'd10000;
   localparam logic [MS_WIDTH-1:0] MOVE_TIMEOUT_RESET = 16'd30000;

   localparam logic [7:0] PIN_SELECT = 8'h01;
   localparam logic [7:0] PIN_VALID  = 8'h02;
   localparam logic [7:0] PIN_TRREQ  = 8'h04;
   localparam logic [7:0] PIN_BUSY   = 8'h08;
   localparam logic [7:0] PIN_COMPT  = 8'h10;
   localparam logic [7:0] PIN_CS     = 8'hE0;

   localparam logic [1:0] MOVE_CONFIRMED = 2'd1;
   localparam logic [1:0] MOVE_DONE      = 2'd2;
   localparam logic [1:0] MOVE_FAULT     = 2'd3;

   localparam logic [1:0] DONE_RUNNING = 2'd0;
   localparam logic [1:0] DONE_SUCCESS = 2'd1;
   localparam logic [1:0] DONE_ERROR   = 2'd2;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_ID_GO       = 3'd1;
   localparam logic [2:0] ERR_VALID       = 3'd2;
   localparam logic [2:0] ERR_REQ         = 3'd3;
   localparam logic [2:0] ERR_CARRIER     = 3'd4;
   localparam logic [2:0] ERR_NO_READY    = 3'd5;
   localparam logic [2:0] ERR_END_TIMEOUT = 3'd6;

   localparam logic [3:0] TASK_ACQUIRE_A = 4'd1;
   localparam logic [3:0] TASK_ACQUIRE_B = 4'd4;
   localparam logic [3:0] TASK_CHARGER   = 4'd10;
   localparam logic [3:0] ID_CHARGER     = 4'd9;
   localparam logic [3:0] TASK_LAST      = 4'd13;

   typedef struct packed {
      logic       req_type;
      logic [3:0] task_req;
      logic       id_ack;
      logic       go_line;
      logic       unload_req;
      logic       load_req;
      logic       ready_line;
      logic       tray_front;
      logic       tray_rear;
      logic [1:0] move_status;
      logic       valid_readback;
      logic       trreq_readback;
   } req_payload_type;

   typedef struct packed {
      logic       select_pin;
      logic       valid_pin;
      logic       trreq_pin;
      logic       busy_pin;
      logic       compt_pin;
      logic [2:0] cs_pins;
      logic       id_publish;
      logic [3:0] id_index;
      logic       busy_report;
      logic [1:0] done_status;
      logic [2:0] fault_code;
      logic       move_error;
   } rsp_payload_type;

   function automatic logic [3:0] id_of_task(input logic [3:0] task_num);
      logic [3:0] id;
      if (task_num == TASK_CHARGER) begin
         id = ID_CHARGER;
      end else if (task_num != 4'd0 && task_num <= TASK_LAST) begin
         id = task_num;
      end else begin
         id = 4'd0;
      end
      return id;
   endfunction

endpackage

FILE: design/dhs_channels.sv
// Interfaces: valid/ready channels for request and response transfers.
`timescale 1ns / 1ps
interface dhs_req_if;
   logic                     valid;
   logic                     ready;
   dhs_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dhs_rsp_if;
   logic                     valid;
   logic                     ready;
   dhs_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/docking_handshake_sequencer.sv
// Top level: docking transfer handshake sequencer with APB register port.
// Each accepted request yields one registered response; one request per cycle
// while the skid register is empty. The step update is combinational; a
// two-entry output (result register plus skid register) accepts one more
// request while a response stalls; request ready is low while the skid is full.
// Reset: idle end state, timer and error cleared, pins low, registers at defaults.
`timescale 1ns / 1ps
module docking_handshake_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   dhs_req_if.sink                              req_if,
   dhs_rsp_if.source                            rsp_if,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dhs_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [dhs_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [dhs_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                 pready
);
   import dhs_pkg::*;

   typedef enum logic [3:0] {
      ST_START, ST_SEL_DWELL, ST_ID_WAIT, ST_GO_WAIT, ST_REQ_WAIT, ST_CARRIER,
      ST_TRREQ_ON, ST_READY_ON, ST_MOVE_CONF, ST_MOVE_DONE, ST_FINISH,
      ST_READY_OFF, ST_ERROR, ST_SUCCESS, ST_END
   } step_type;

   logic [MS_WIDTH-1:0] dwell_ff, comm_ff, move_ff;
   step_type            state_ff, state_in;
   logic [MS_WIDTH-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [7:0]          pins_ff, pins_in;
   logic [2:0]          err_ff, err_in;

   logic                out_valid_ff, skid_valid_ff;
   rsp_payload_type     out_data_ff, skid_data_ff, result;

   logic                req_fire, rsp_fire, csr_write;
   logic                dwell, comm, publish, report, merr;
   logic [3:0]          idx;
   logic [1:0]          done;
   req_payload_type     rq;

   assign rq        = req_if.data;
   assign req_if.ready = !skid_valid_ff;
   assign req_fire  = req_if.valid && req_if.ready;
   assign rsp_fire  = out_valid_ff && rsp_if.ready;
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff <= SELECT_DWELL_RESET;
         comm_ff  <= COMM_TIMEOUT_RESET;
         move_ff  <= MOVE_TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_SELECT_DWELL: dwell_ff <= pwdata[MS_WIDTH-1:0];
            REG_COMM_TIMEOUT: comm_ff  <= pwdata[MS_WIDTH-1:0];
            REG_MOVE_TIMEOUT: move_ff  <= pwdata[MS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_SELECT_DWELL: prdata = {{(CSR_DATA_WIDTH-MS_WIDTH){1'b0}}, dwell_ff};
         REG_COMM_TIMEOUT: prdata = {{(CSR_DATA_WIDTH-MS_WIDTH){1'b0}}, comm_ff};
         REG_MOVE_TIMEOUT: prdata = {{(CSR_DATA_WIDTH-MS_WIDTH){1'b0}}, move_ff};
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      elapsed_in  = elapsed_ff;
      pins_in     = pins_ff;
      err_in      = err_ff;
      publish     = 1'b0;
      idx         = 4'd0;
      report      = 1'b0;
      done        = DONE_RUNNING;
      merr        = 1'b0;
      elapsed_inc = (elapsed_ff == {MS_WIDTH{1'b1}}) ? elapsed_ff : elapsed_ff + 16'd1;
      dwell       = elapsed_inc >= dwell_ff;
      comm        = elapsed_inc >= comm_ff;

      if (rq.req_type) begin
         state_in   = ST_START;
         elapsed_in = '0;
         err_in     = ERR_NONE;
      end else begin
         elapsed_in = elapsed_inc;
         unique case (state_ff)
            ST_START: begin
               pins_in    = pins_ff | PIN_SELECT;
               elapsed_in = '0;
               state_in   = ST_SEL_DWELL;
            end
            ST_SEL_DWELL: begin
               if (dwell) begin
                  publish    = 1'b1;
                  idx        = id_of_task(rq.task_req);
                  elapsed_in = '0;
                  state_in   = ST_ID_WAIT;
               end
            end
            ST_ID_WAIT: begin
               if (dwell) begin
                  if (rq.id_ack) begin
                     pins_in    = pins_ff & ~PIN_SELECT;
                     elapsed_in = '0;
                     state_in   = ST_GO_WAIT;
                  end else if (comm) begin
                     err_in     = ERR_ID_GO;
                     elapsed_in = '0;
                     state_in   = ST_ERROR;
                  end
               end
            end
            ST_GO_WAIT: begin
               if (dwell) begin
                  if (rq.go_line) begin
                     pins_in    = pins_ff | PIN_VALID;
                     elapsed_in = '0;
                     state_in   = ST_REQ_WAIT;
                  end else if (comm) begin
                     err_in     = ERR_VALID;
                     elapsed_in = '0;
                     state_in   = ST_ERROR;
                  end
               end
            end
            ST_REQ_WAIT: begin
               if (rq.unload_req) begin
                  elapsed_in = '0;
                  state_in   = ST_CARRIER;
               end else if (rq.load_req) begin
                  elapsed_in = '0;
                  state_in   = ST_TRREQ_ON;
               end else if (comm) begin
                  err_in     = ERR_REQ;
                  elapsed_in = '0;
                  state_in   = ST_ERROR;
               end else if (!rq.valid_readback) begin
                  pins_in = pins_ff | PIN_VALID;
               end
            end
            ST_CARRIER: begin
               if ((rq.task_req == TASK_ACQUIRE_A || rq.task_req == TASK_ACQUIRE_B)
                   && (rq.tray_front || rq.tray_rear)) begin
                  err_in     = ERR_CARRIER;
                  elapsed_in = '0;
                  state_in   = ST_ERROR;
               end else begin
                  state_in = ST_TRREQ_ON;
               end
            end
            ST_TRREQ_ON: begin
               pins_in    = pins_ff | PIN_TRREQ;
               elapsed_in = '0;
               state_in   = ST_READY_ON;
            end
            ST_READY_ON: begin
               if (rq.ready_line) begin
                  pins_in    = pins_ff | PIN_BUSY;
                  report     = 1'b1;
                  elapsed_in = '0;
                  state_in   = ST_MOVE_CONF;
               end else if (elapsed_inc >= move_ff) begin
                  err_in     = ERR_NO_READY;
                  elapsed_in = '0;
                  state_in   = ST_ERROR;
               end else if (!rq.trreq_readback) begin
                  pins_in = pins_ff | PIN_TRREQ;
               end
            end
            ST_MOVE_CONF: begin
               if (rq.move_status == MOVE_CONFIRMED) begin
                  elapsed_in = '0;
                  state_in   = ST_MOVE_DONE;
               end
            end
            ST_MOVE_DONE: begin
               if (rq.move_status == MOVE_DONE) begin
                  elapsed_in = '0;
                  state_in   = ST_FINISH;
               end else if (rq.move_status == MOVE_FAULT) begin
                  elapsed_in = '0;
                  merr       = 1'b1;
               end
            end
            ST_FINISH: begin
               pins_in    = (pins_ff & ~(PIN_BUSY | PIN_TRREQ)) | PIN_COMPT;
               elapsed_in = '0;
               state_in   = ST_READY_OFF;
            end
            ST_READY_OFF: begin
               if (!rq.ready_line) begin
                  pins_in    = pins_ff & ~(PIN_COMPT | PIN_VALID | PIN_CS);
                  elapsed_in = '0;
                  state_in   = ST_SUCCESS;
               end else if (comm) begin
                  err_in     = ERR_END_TIMEOUT;
                  elapsed_in = '0;
                  state_in   = ST_ERROR;
               end
            end
            ST_ERROR: begin
               done     = DONE_ERROR;
               state_in = ST_END;
            end
            ST_SUCCESS: begin
               done     = DONE_SUCCESS;
               state_in = ST_END;
            end
            default: begin
               state_in = ST_END;
            end
         endcase
      end

      result.select_pin  = pins_in[0];
      result.valid_pin   = pins_in[1];
      result.trreq_pin   = pins_in[2];
      result.busy_pin    = pins_in[3];
      result.compt_pin   = pins_in[4];
      result.cs_pins     = pins_in[7:5];
      result.id_publish  = publish;
      result.id_index    = idx;
      result.busy_report = report;
      result.done_status = done;
      result.fault_code  = err_in;
      result.move_error  = merr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_END;
         elapsed_ff <= '0;
         pins_ff    <= '0;
         err_ff     <= ERR_NONE;
      end else if (req_fire) begin
         state_ff   <= state_in;
         elapsed_ff <= elapsed_in;
         pins_ff    <= pins_in;
         err_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_fire || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_fire;
         end
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire || !out_valid_ff) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end
      if (req_fire && out_valid_ff && !rsp_fire) begin
         skid_data_ff <= result;
      end
   end

endmodule

FILE: verif/docking_handshake_sequencer_checker.sv
// Checker: predicts docking handshake outputs and compares response and register transfers.
`timescale 1ns / 1ps
module docking_handshake_sequencer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  dhs_pkg::req_payload_type           req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  dhs_pkg::rsp_payload_type           rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic                               pready,
   input  logic [dhs_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [dhs_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   input  logic [dhs_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output int                                 pending_results,
   output int                                 mismatch_total,
   output int                                 results_checked,
   output int                                 sequences_completed,
   output int                                 sequences_aborted
);
   import dhs_pkg::*;

   typedef enum logic [4:0] {
      STEP_START,
      STEP_SEL_DWELL,
      STEP_ID_WAIT,
      STEP_GO_WAIT,
      STEP_REQ_WAIT,
      STEP_CARRIER,
      STEP_TRREQ_ON,
      STEP_READY_ON,
      STEP_MOVE_CONF,
      STEP_MOVE_DONE,
      STEP_FINISH,
      STEP_READY_OFF,
      STEP_ERROR,
      STEP_SUCCESS,
      STEP_END
   } step_type;

   step_type            step;
   logic [MS_WIDTH-1:0] elapsed_ms;
   logic [MS_WIDTH-1:0] dwell_ms;
   logic [MS_WIDTH-1:0] comm_ms;
   logic [MS_WIDTH-1:0] move_ms;
   logic [7:0]          pins;
   logic [2:0]          error_latch;
   rsp_payload_type     predicted_outputs[$];
   rsp_payload_type     oldest;
   int                  mismatches;
   int                  checked;
   int                  completed;
   int                  aborted;

   function automatic void report_mismatch(input string what, input int unsigned want,
                                           input int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %0d at %0t: %s expected %0h actual %0h",
                  mismatches, $time, what, want, got);
      end
   endfunction

   function automatic logic [3:0] published_id(input logic [3:0] task_num);
      logic [3:0] id;
      if (task_num == 4'd0 || task_num > TASK_LAST) begin
         id = 4'd0;
      end else if (task_num == TASK_CHARGER) begin
         id = ID_CHARGER;
      end else begin
         id = task_num;
      end
      return id;
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] register_value(input logic [1:0] index);
      logic [CSR_DATA_WIDTH-1:0] value;
      value = '0;
      case (index)
         REG_SELECT_DWELL: value[MS_WIDTH-1:0] = dwell_ms;
         REG_COMM_TIMEOUT: value[MS_WIDTH-1:0] = comm_ms;
         REG_MOVE_TIMEOUT: value[MS_WIDTH-1:0] = move_ms;
         default: value = '0;
      endcase
      return value;
   endfunction

   function automatic void enter_error(input logic [2:0] code);
      error_latch = code;
      elapsed_ms = '0;
      step = STEP_ERROR;
   endfunction

   function automatic rsp_payload_type advance_handshake(input req_payload_type item);
      rsp_payload_type result;
      logic            dwell_met;
      logic            comm_met;
      result = '0;
      if (item.req_type) begin
         step = STEP_START;
         elapsed_ms = '0;
         error_latch = ERR_NONE;
      end else begin
         if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
         dwell_met = elapsed_ms >= dwell_ms;
         comm_met = elapsed_ms >= comm_ms;
         case (step)
            STEP_START: begin
               pins |= PIN_SELECT;
               elapsed_ms = '0;
               step = STEP_SEL_DWELL;
            end
            STEP_SEL_DWELL: begin
               if (dwell_met) begin
                  result.id_publish = 1'b1;
                  result.id_index = published_id(item.task_req);
                  elapsed_ms = '0;
                  step = STEP_ID_WAIT;
               end
            end
            STEP_ID_WAIT: begin
               if (dwell_met && item.id_ack) begin
                  pins &= ~PIN_SELECT;
                  elapsed_ms = '0;
                  step = STEP_GO_WAIT;
               end else if (dwell_met && comm_met) begin
                  enter_error(ERR_ID_GO);
               end
            end
            STEP_GO_WAIT: begin
               if (dwell_met && item.go_line) begin
                  pins |= PIN_VALID;
                  elapsed_ms = '0;
                  step = STEP_REQ_WAIT;
               end else if (dwell_met && comm_met) begin
                  enter_error(ERR_VALID);
               end
            end
            STEP_REQ_WAIT: begin
               if (item.unload_req) begin
                  elapsed_ms = '0;
                  step = STEP_CARRIER;
               end else if (item.load_req) begin
                  elapsed_ms = '0;
                  step = STEP_TRREQ_ON;
               end else if (comm_met) begin
                  enter_error(ERR_REQ);
               end else if (!item.valid_readback) begin
                  pins |= PIN_VALID;
               end
            end
            STEP_CARRIER: begin
               if ((item.task_req == TASK_ACQUIRE_A || item.task_req == TASK_ACQUIRE_B)
                   && (item.tray_front || item.tray_rear)) begin
                  enter_error(ERR_CARRIER);
               end else begin
                  step = STEP_TRREQ_ON;
               end
            end
            STEP_TRREQ_ON: begin
               pins |= PIN_TRREQ;
               elapsed_ms = '0;
               step = STEP_READY_ON;
            end
            STEP_READY_ON: begin
               if (item.ready_line) begin
                  pins |= PIN_BUSY;
                  result.busy_report = 1'b1;
                  elapsed_ms = '0;
                  step = STEP_MOVE_CONF;
               end else if (elapsed_ms >= move_ms) begin
                  enter_error(ERR_NO_READY);
               end else if (!item.trreq_readback) begin
                  pins |= PIN_TRREQ;
               end
            end
            STEP_MOVE_CONF: begin
               if (item.move_status == MOVE_CONFIRMED) begin
                  elapsed_ms = '0;
                  step = STEP_MOVE_DONE;
               end
            end
            STEP_MOVE_DONE: begin
               if (item.move_status == MOVE_DONE) begin
                  elapsed_ms = '0;
                  step = STEP_FINISH;
               end else if (item.move_status == MOVE_FAULT) begin
                  elapsed_ms = '0;
                  result.move_error = 1'b1;
               end
            end
            STEP_FINISH: begin
               pins &= ~(PIN_BUSY | PIN_TRREQ);
               pins |= PIN_COMPT;
               elapsed_ms = '0;
               step = STEP_READY_OFF;
            end
            STEP_READY_OFF: begin
               if (!item.ready_line) begin
                  pins &= ~(PIN_COMPT | PIN_VALID | PIN_CS);
                  elapsed_ms = '0;
                  step = STEP_SUCCESS;
               end else if (comm_met) begin
                  enter_error(ERR_END_TIMEOUT);
               end
            end
            STEP_ERROR: begin
               result.done_status = DONE_ERROR;
               step = STEP_END;
            end
            STEP_SUCCESS: begin
               result.done_status = DONE_SUCCESS;
               step = STEP_END;
            end
            default: step = STEP_END;
         endcase
      end
      result.select_pin = |(pins & PIN_SELECT);
      result.valid_pin = |(pins & PIN_VALID);
      result.trreq_pin = |(pins & PIN_TRREQ);
      result.busy_pin = |(pins & PIN_BUSY);
      result.compt_pin = |(pins & PIN_COMPT);
      result.cs_pins = pins[7:5];
      result.fault_code = error_latch;
      return result;
   endfunction

   function automatic void compare_outputs(input rsp_payload_type want,
                                           input rsp_payload_type got);
      if (got.select_pin !== want.select_pin)
         report_mismatch("select_pin", want.select_pin, got.select_pin);
      if (got.valid_pin !== want.valid_pin)
         report_mismatch("valid_pin", want.valid_pin, got.valid_pin);
      if (got.trreq_pin !== want.trreq_pin)
         report_mismatch("trreq_pin", want.trreq_pin, got.trreq_pin);
      if (got.busy_pin !== want.busy_pin)
         report_mismatch("busy_pin", want.busy_pin, got.busy_pin);
      if (got.compt_pin !== want.compt_pin)
         report_mismatch("compt_pin", want.compt_pin, got.compt_pin);
      if (got.cs_pins !== want.cs_pins)
         report_mismatch("cs_pins", want.cs_pins, got.cs_pins);
      if (got.id_publish !== want.id_publish)
         report_mismatch("id_publish", want.id_publish, got.id_publish);
      if (got.id_index !== want.id_index)
         report_mismatch("id_index", want.id_index, got.id_index);
      if (got.busy_report !== want.busy_report)
         report_mismatch("busy_report", want.busy_report, got.busy_report);
      if (got.done_status !== want.done_status)
         report_mismatch("done_status", want.done_status, got.done_status);
      if (got.fault_code !== want.fault_code)
         report_mismatch("fault_code", want.fault_code, got.fault_code);
      if (got.move_error !== want.move_error)
         report_mismatch("move_error", want.move_error, got.move_error);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         step = STEP_END;
         elapsed_ms = '0;
         pins = '0;
         error_latch = ERR_NONE;
         dwell_ms = SELECT_DWELL_RESET;
         comm_ms = COMM_TIMEOUT_RESET;
         move_ms = MOVE_TIMEOUT_RESET;
         predicted_outputs.delete();
         mismatches = 0;
         checked = 0;
         completed = 0;
         aborted = 0;
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[CSR_ADDR_WIDTH-1:2])
                  REG_SELECT_DWELL: dwell_ms = pwdata[MS_WIDTH-1:0];
                  REG_COMM_TIMEOUT: comm_ms = pwdata[MS_WIDTH-1:0];
                  REG_MOVE_TIMEOUT: move_ms = pwdata[MS_WIDTH-1:0];
                  default: ;
               endcase
            end else if (prdata !== register_value(paddr[CSR_ADDR_WIDTH-1:2])) begin
               report_mismatch("register read", register_value(paddr[CSR_ADDR_WIDTH-1:2]),
                               prdata);
            end
         end
         if (req_valid && req_ready) begin
            predicted_outputs.push_back(advance_handshake(req_data));
            if (predicted_outputs[$].done_status == DONE_SUCCESS) completed++;
            if (predicted_outputs[$].done_status == DONE_ERROR) aborted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               report_mismatch("unexpected response", 0, 32'(rsp_data));
            end else begin
               oldest = predicted_outputs.pop_front();
               compare_outputs(oldest, rsp_data);
               checked++;
            end
         end
      end
      pending_results <= predicted_outputs.size();
      mismatch_total <= mismatches;
      results_checked <= checked;
      sequences_completed <= completed;
      sequences_aborted <= aborted;
   end

endmodule

FILE: verif/docking_handshake_sequencer_test.sv
// Testbench top: clock, reset, request and register stimulus, response stalls and verdict.
`timescale 1ns / 1ps
module docking_handshake_sequencer_test;
   import dhs_pkg::*;

   localparam int ITEM_BITS = $bits(req_payload_type);
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CEILING_TICKS = 60;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int pending_results;
   int mismatch_total;
   int results_checked;
   int sequences_completed;
   int sequences_aborted;
   int items_sent;
   int settings_used;
   bit sender_gaps;
   bit hold_off_wanted;
   bit hold_off_done;

   dhs_req_if req_chan ();
   dhs_rsp_if rsp_chan ();

   docking_handshake_sequencer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_chan),
      .rsp_if  (rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   docking_handshake_sequencer_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_chan.valid),
      .req_ready           (req_chan.ready),
      .req_data            (req_chan.data),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_data            (rsp_chan.data),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .pready              (pready),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pending_results     (pending_results),
      .mismatch_total      (mismatch_total),
      .results_checked     (results_checked),
      .sequences_completed (sequences_completed),
      .sequences_aborted   (sequences_aborted)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic chance(input int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic req_payload_type sequence_tick(input logic [3:0] seq_task);
      req_payload_type item;
      item = '0;
      item.task_req = chance(85) ? seq_task : 4'($urandom);
      item.id_ack = chance(60);
      item.go_line = chance(60);
      item.unload_req = chance(30);
      item.load_req = chance(30);
      item.ready_line = chance(50);
      item.tray_front = chance(12);
      item.tray_rear = chance(12);
      item.move_status = 2'($urandom);
      item.valid_readback = chance(50);
      item.trreq_readback = chance(50);
      return item;
   endfunction

   initial begin
      int burst;
      int gap;
      rsp_chan.ready = 1'b0;
      hold_off_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_wanted && !hold_off_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_chan.ready <= 1'b1;
         burst = chance(10) ? $urandom_range(100, 300) : $urandom_range(1, 30);
         repeat (burst) begin
            @(posedge clock);
            if (hold_off_wanted && !hold_off_done) break;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic send_item(input req_payload_type item);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= item;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic access_register(input logic write_en, input logic [1:0] index,
                                  input logic [MS_WIDTH-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write_en;
      paddr <= {index, 2'b00};
      pwdata <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input logic [MS_WIDTH-1:0] dwell, input logic [MS_WIDTH-1:0] comm,
                             input logic [MS_WIDTH-1:0] move);
      drain_results();
      access_register(1'b1, REG_SELECT_DWELL, dwell);
      access_register(1'b1, REG_COMM_TIMEOUT, comm);
      access_register(1'b1, REG_MOVE_TIMEOUT, move);
      access_register(1'b0, REG_SELECT_DWELL, '0);
      access_register(1'b0, REG_COMM_TIMEOUT, '0);
      access_register(1'b0, REG_MOVE_TIMEOUT, '0);
      settings_used++;
   endtask

   task automatic run_directed();
      req_payload_type item;
      item = '1;
      item.req_type = 1'b0;
      send_item(item);
      item = '0;
      item.req_type = 1'b1;
      item.task_req = TASK_ACQUIRE_A;
      send_item(item);
      item.req_type = 1'b0;
      send_item(item);
      send_item(item);
      item.id_ack = 1'b1;
      send_item(item);
      item.go_line = 1'b1;
      send_item(item);
      item.unload_req = 1'b1;
      send_item(item);
      item.tray_front = 1'b1;
      send_item(item);
      send_item(item);

      item = '0;
      item.req_type = 1'b1;
      item.task_req = TASK_CHARGER;
      send_item(item);
      item.req_type = 1'b0;
      item.valid_readback = 1'b1;
      item.trreq_readback = 1'b1;
      send_item(item);
      send_item(item);
      item.id_ack = 1'b1;
      send_item(item);
      item.go_line = 1'b1;
      send_item(item);
      item.valid_readback = 1'b0;
      send_item(item);
      item.load_req = 1'b1;
      send_item(item);
      send_item(item);
      item.trreq_readback = 1'b0;
      send_item(item);
      item.ready_line = 1'b1;
      send_item(item);
      item.move_status = MOVE_CONFIRMED;
      send_item(item);
      item.move_status = MOVE_FAULT;
      send_item(item);
      item.move_status = MOVE_DONE;
      send_item(item);
      send_item(item);
      item.ready_line = 1'b0;
      send_item(item);
      send_item(item);
   endtask

   task automatic run_sequences(input int item_budget);
      req_payload_type item;
      logic [3:0]      seq_task;
      int              sent;
      int              ticks;
      sent = 0;
      while (sent < item_budget) begin
         if (chance(10)) begin
            item = ITEM_BITS'($urandom);
            if (chance(75)) item.req_type = 1'b0;
            send_item(item);
            sent++;
         end else begin
            if (chance(30)) seq_task = chance(50) ? TASK_ACQUIRE_A : TASK_ACQUIRE_B;
            else seq_task = 4'($urandom);
            item = sequence_tick(seq_task);
            item.req_type = 1'b1;
            send_item(item);
            sent++;
            ticks = $urandom_range(4, 40);
            repeat (ticks) begin
               send_item(sequence_tick(seq_task));
               sent++;
            end
         end
      end
   endtask

   task automatic run_timer_ceiling();
      req_payload_type item;
      logic [3:0]      seq_task;
      seq_task = 4'($urandom);
      item = sequence_tick(seq_task);
      item.req_type = 1'b1;
      send_item(item);
      repeat (CEILING_TICKS) begin
         item = sequence_tick(seq_task);
         item.id_ack = 1'b0;
         send_item(item);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      sender_gaps = 1'b1;
      hold_off_wanted = 1'b0;
      items_sent = 0;
      settings_used = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      set_timing(16'd0, 16'd3, 16'd2);
      run_directed();
      set_timing(16'd0, 16'd0, 16'd0);
      run_sequences(150);
      set_timing(16'hFFFF, 16'd8, 16'd8);
      run_sequences(60);
      repeat (6) begin
         set_timing(16'($urandom_range(0, 3)), 16'($urandom_range(2, 14)),
                    16'($urandom_range(1, 10)));
         sender_gaps = chance(70);
         run_sequences(120);
      end
      set_timing(16'd2, 16'd3, 16'd4);
      sender_gaps = 1'b0;
      hold_off_wanted = 1'b1;
      run_sequences(300);
      sender_gaps = 1'b1;
      set_timing(16'd1, 16'hFFFF, 16'hFFFF);
      run_sequences(200);
      set_timing(16'd0, 16'hFFFF, 16'd5);
      sender_gaps = 1'b0;
      run_timer_ceiling();
      sender_gaps = 1'b1;
      set_timing(SELECT_DWELL_RESET, COMM_TIMEOUT_RESET, MOVE_TIMEOUT_RESET);
      run_sequences(40);
      drain_results();
      repeat (8) @(posedge clock);

      $display("summary: %0d request transfers, %0d responses checked, %0d timing settings",
               items_sent, results_checked, settings_used);
      $display("summary: %0d handshakes completed, %0d ended on an error code, %0d mismatches",
               sequences_completed, sequences_aborted, mismatch_total);
      if (mismatch_total == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
